FILE: sv/gcs_pkg.sv
// Shared types, constants and counter helpers for the greedy coin-set search.
// No dependencies; every other file imports this package.
package gcs_pkg;

  localparam int AMOUNT_W = 10;
  localparam int TOTAL_W  = 19;
  localparam int ADDR_W   = 3;
  localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = {AMOUNT_W{1'b1}};
  localparam logic [AMOUNT_W-1:0] MAX_AMOUNT_RST = AMOUNT_W'(99);
  localparam logic [TOTAL_W-1:0]  TOTAL_BOUND = TOTAL_W'(523776);

  typedef logic [AMOUNT_W-1:0] amt_t;
  typedef logic [AMOUNT_W:0]   amt_ext_t;
  typedef logic [TOTAL_W-1:0]  total_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_MAX_AMOUNT = 1'b0,
    REG_NONE       = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_EVAL = 2'd0,
    CMD_TOP  = 2'd1,
    CMD_MID  = 2'd2,
    CMD_PAIR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SUM,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    amt_t cnt;
    amt_t quo;
    logic wrap;
  } ctr_t;

  // one greedy step: remainder counts up and wraps at the coin value,
  // the quotient counts the wraps; a zero coin never wraps
  function automatic ctr_t step_ctr(amt_t cnt, amt_t quo, amt_t coin);
    amt_ext_t inc;
    ctr_t     res;
    inc      = {1'b0, cnt} + amt_ext_t'(1);
    res.wrap = (inc == {1'b0, coin});
    res.cnt  = res.wrap ? '0 : inc[AMOUNT_W-1:0];
    res.quo  = quo + amt_t'(res.wrap);
    return res;
  endfunction

  function automatic amt_t sat_inc(amt_t v, logic [1:0] k);
    amt_ext_t s;
    s = {1'b0, v} + amt_ext_t'(k);
    return (s > {1'b0, AMOUNT_MAX}) ? AMOUNT_MAX : s[AMOUNT_W-1:0];
  endfunction

endpackage

FILE: sv/gcs_ram.sv
// Partial-count table: one write port, one read port, registered read data.
// Depends on gcs_pkg.
module gcs_ram (
  input  logic          clk,
  input  logic          wr_en,
  input  gcs_pkg::amt_t wr_addr,
  input  gcs_pkg::amt_t wr_data,
  input  gcs_pkg::amt_t rd_addr,
  output gcs_pkg::amt_t rd_data
);
  import gcs_pkg::*;

  amt_t mem [2**AMOUNT_W];
  amt_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/gcs_core.sv
// Search sequencer and greedy-count datapath: fills the partial-count table,
// walks amounts 1..D once per coin set, keeps the best set, registers result.
// Depends on gcs_pkg and gcs_ram.
module gcs_core (
  input  logic            clk,
  input  logic            rst_n,
  input  gcs_pkg::amt_t   max_amount,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_command,
  input  gcs_pkg::amt_t   in_coin_small,
  input  gcs_pkg::amt_t   in_coin_mid,
  input  gcs_pkg::amt_t   in_coin_top,
  output logic            out_valid,
  input  logic            out_ready,
  output gcs_pkg::amt_t   out_best_mid,
  output gcs_pkg::amt_t   out_best_top,
  output gcs_pkg::total_t out_total_coins
);
  import gcs_pkg::*;

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;
  amt_t   small_r, small_nxt;
  amt_t   mid_r, mid_nxt;
  amt_t   top_r, top_nxt;
  logic   first_r, first_nxt;
  amt_t   amt_r, amt_nxt;
  amt_t   fm_rm_r, fm_rm_nxt, fm_qm_r, fm_qm_nxt;
  amt_t   fm_rs_r, fm_rs_nxt, fm_qs_r, fm_qs_nxt;
  amt_t   st_r, st_nxt, sq_r, sq_nxt;
  logic   vld_r, vld_nxt;
  total_t acc_r, acc_nxt;
  total_t best_cnt_r, best_cnt_nxt;
  amt_t   best_mid_r, best_mid_nxt;
  amt_t   best_top_r, best_top_nxt;
  logic   out_valid_r, out_valid_nxt;
  amt_t   out_mid_r, out_mid_nxt;
  amt_t   out_top_r, out_top_nxt;
  total_t out_tot_r, out_tot_nxt;

  ctr_t     m_step, s_step, t_step;
  amt_ext_t top_inc, mid_inc, d_ext;
  logic     go_fill, go_sum, better;
  logic     wr_en;
  amt_t     wr_data, rd_data;

  gcs_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (amt_r),
    .wr_data (wr_data),
    .rd_addr (t_step.cnt),
    .rd_data (rd_data)
  );

  assign m_step  = step_ctr(fm_rm_r, fm_qm_r, mid_r);
  assign s_step  = step_ctr(fm_rs_r, fm_qs_r, small_r);
  assign t_step  = step_ctr(st_r, sq_r, top_r);
  assign top_inc = {1'b0, top_r} + amt_ext_t'(1);
  assign mid_inc = {1'b0, mid_r} + amt_ext_t'(1);
  assign d_ext   = {1'b0, max_amount};
  assign better  = first_r || (acc_r < best_cnt_r);
  assign wr_en   = (state_r == ST_FILL);
  assign wr_data = fm_qm_r + fm_qs_r + fm_rs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
      vld_r       <= 1'b0;
      amt_r       <= '0;
      best_cnt_r  <= '0;
      best_mid_r  <= '0;
      best_top_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
      vld_r       <= vld_nxt;
      amt_r       <= amt_nxt;
      best_cnt_r  <= best_cnt_nxt;
      best_mid_r  <= best_mid_nxt;
      best_top_r  <= best_top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    small_r   <= small_nxt;
    mid_r     <= mid_nxt;
    top_r     <= top_nxt;
    fm_rm_r   <= fm_rm_nxt;
    fm_qm_r   <= fm_qm_nxt;
    fm_rs_r   <= fm_rs_nxt;
    fm_qs_r   <= fm_qs_nxt;
    st_r      <= st_nxt;
    sq_r      <= sq_nxt;
    acc_r     <= acc_nxt;
    out_mid_r <= out_mid_nxt;
    out_top_r <= out_top_nxt;
    out_tot_r <= out_tot_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    small_nxt     = small_r;
    mid_nxt       = mid_r;
    top_nxt       = top_r;
    first_nxt     = first_r;
    amt_nxt       = amt_r;
    fm_rm_nxt     = fm_rm_r;
    fm_qm_nxt     = fm_qm_r;
    fm_rs_nxt     = fm_rs_r;
    fm_qs_nxt     = fm_qs_r;
    st_nxt        = st_r;
    sq_nxt        = sq_r;
    vld_nxt       = vld_r;
    acc_nxt       = acc_r;
    best_cnt_nxt  = best_cnt_r;
    best_mid_nxt  = best_mid_r;
    best_top_nxt  = best_top_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_mid_nxt   = out_mid_r;
    out_top_nxt   = out_top_r;
    out_tot_nxt   = out_tot_r;
    go_fill       = 1'b0;
    go_sum        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd_t'(in_command);
          small_nxt = in_coin_small;
          first_nxt = 1'b1;
          go_fill   = 1'b1;
          unique case (cmd_t'(in_command))
            CMD_EVAL: begin
              mid_nxt = in_coin_mid;
              top_nxt = in_coin_top;
            end
            CMD_TOP: begin
              mid_nxt = in_coin_mid;
              top_nxt = sat_inc(in_coin_mid, 2'd1);
            end
            CMD_MID: begin
              mid_nxt = sat_inc(in_coin_small, 2'd1);
              top_nxt = in_coin_top;
            end
            CMD_PAIR: begin
              mid_nxt = sat_inc(in_coin_small, 2'd1);
              top_nxt = sat_inc(in_coin_small, 2'd2);
            end
          endcase
        end
      end

      ST_FILL: begin
        fm_rm_nxt = m_step.cnt;
        fm_qm_nxt = m_step.quo;
        if (m_step.wrap) begin
          fm_rs_nxt = '0;
          fm_qs_nxt = '0;
        end else begin
          fm_rs_nxt = s_step.cnt;
          fm_qs_nxt = s_step.quo;
        end
        if (amt_r == max_amount) begin
          go_sum = 1'b1;
        end else begin
          amt_nxt = amt_r + amt_t'(1);
        end
      end

      ST_SUM: begin
        if (vld_r) begin
          acc_nxt = acc_r + total_t'(sq_r) + total_t'(rd_data);
        end
        if (amt_r < max_amount) begin
          st_nxt  = t_step.cnt;
          sq_nxt  = t_step.quo;
          vld_nxt = 1'b1;
          amt_nxt = amt_r + amt_t'(1);
        end else begin
          vld_nxt   = 1'b0;
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (better) begin
          best_cnt_nxt = acc_r;
          best_mid_nxt = mid_r;
          best_top_nxt = top_r;
        end
        first_nxt = 1'b0;
        state_nxt = ST_DONE;
        unique case (cmd_r)
          CMD_EVAL: ;
          CMD_TOP: begin
            if (top_inc <= d_ext) begin
              top_nxt = top_inc[AMOUNT_W-1:0];
              go_sum  = 1'b1;
            end
          end
          CMD_MID: begin
            if (mid_inc < {1'b0, top_r}) begin
              mid_nxt = mid_inc[AMOUNT_W-1:0];
              go_fill = 1'b1;
            end
          end
          CMD_PAIR: begin
            priority if (first_r) begin
              if (mid_r < max_amount) begin
                top_nxt = mid_inc[AMOUNT_W-1:0];
                go_sum  = 1'b1;
              end
            end else if (top_inc <= d_ext) begin
              top_nxt = top_inc[AMOUNT_W-1:0];
              go_sum  = 1'b1;
            end else if (mid_inc < d_ext) begin
              mid_nxt = mid_inc[AMOUNT_W-1:0];
              top_nxt = mid_inc[AMOUNT_W-1:0] + amt_t'(1);
              go_fill = 1'b1;
            end
          end
        endcase
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_mid_nxt   = best_mid_r;
          out_top_nxt   = best_top_r;
          out_tot_nxt   = best_cnt_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (go_fill) begin
      state_nxt = ST_FILL;
      amt_nxt   = '0;
      fm_rm_nxt = '0;
      fm_qm_nxt = '0;
      fm_rs_nxt = '0;
      fm_qs_nxt = '0;
    end
    if (go_sum) begin
      state_nxt = ST_SUM;
      amt_nxt   = '0;
      st_nxt    = '0;
      sq_nxt    = '0;
      acc_nxt   = '0;
      vld_nxt   = 1'b0;
    end
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_best_mid    = out_mid_r;
  assign out_best_top    = out_top_r;
  assign out_total_coins = out_tot_r;

endmodule

FILE: sv/greedy_coin_set_search_top.sv
// Top level of the greedy coin-set search: configuration register port and
// the search core. Depends on gcs_pkg and gcs_core.
//
// Usage: write max_amount (D, address 0) over the APB-style port while idle.
// An item (command, coin_small, coin_mid, coin_top) is taken on the in_
// channel when in_valid and in_ready are high; in_ready is low until the
// item's result has been placed in the output register. One result item
// (best_mid, best_top, total_coins) follows on the out_ channel.
// Each coin set rebuilds the partial-count table (only when the middle coin
// changes), walks amounts 1..D and takes one compare step. Command 0 tries
// one coin set; command 1 steps the top coin, command 2 the middle coin and
// command 3 both. The walk through the table RAM takes one amount per cycle.
// Reset: max_amount returns to 99, the block is idle and out_valid is low.
// A stalled receiver holds the result; the next item can be accepted and
// worked on meanwhile, and its result waits until the register is free.
module greedy_coin_set_search_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [gcs_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_command,
  input  gcs_pkg::amt_t               in_coin_small,
  input  gcs_pkg::amt_t               in_coin_mid,
  input  gcs_pkg::amt_t               in_coin_top,
  output logic                        out_valid,
  input  logic                        out_ready,
  output gcs_pkg::amt_t               out_best_mid,
  output gcs_pkg::amt_t               out_best_top,
  output gcs_pkg::total_t             out_total_coins
);
  import gcs_pkg::*;

  amt_t     max_amount_r, max_amount_nxt;
  reg_idx_t reg_sel;
  logic     wr_hit;

  assign reg_sel    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;
  assign wr_hit     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (reg_sel == REG_MAX_AMOUNT);

  always_comb begin
    max_amount_nxt = wr_hit ? cfg_pwdata[AMOUNT_W-1:0] : max_amount_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_amount_r <= MAX_AMOUNT_RST;
    end else begin
      max_amount_r <= max_amount_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_AMOUNT: cfg_prdata = 32'(max_amount_r);
      default:        cfg_prdata = '0;
    endcase
  end

  gcs_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .max_amount      (max_amount_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_coin_small   (in_coin_small),
    .in_coin_mid     (in_coin_mid),
    .in_coin_top     (in_coin_top),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_best_mid    (out_best_mid),
    .out_best_top    (out_best_top),
    .out_total_coins (out_total_coins)
  );

endmodule

FILE: sv/gcs_checker.sv
// Port-level checks for the greedy coin-set search, bound to the top level.
// Depends on gcs_pkg and greedy_coin_set_search_top.
module gcs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        cfg_psel,
  input logic                        cfg_penable,
  input logic                        cfg_pwrite,
  input logic [gcs_pkg::ADDR_W-1:0]  cfg_paddr,
  input logic [31:0]                 cfg_pwdata,
  input logic [31:0]                 cfg_prdata,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input gcs_pkg::amt_t               out_best_mid,
  input gcs_pkg::amt_t               out_best_top,
  input gcs_pkg::total_t             out_total_coins
);
  import gcs_pkg::*;

  // an accepted item moves the core out of idle, so no second one right behind it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an item was accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_best_mid)
      && $stable(out_best_top) && $stable(out_total_coins)))
    else $error("stalled result item changed");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_total_coins <= TOTAL_BOUND))
    else $error("total_coins beyond the largest possible sum");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) |=>
      (cfg_paddr[2] || (cfg_prdata[AMOUNT_W-1:0] == $past(cfg_pwdata[AMOUNT_W-1:0]))))
    else $error("max_amount does not read back what was written");

endmodule

bind greedy_coin_set_search_top gcs_checker u_gcs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .cfg_psel        (cfg_psel),
  .cfg_penable     (cfg_penable),
  .cfg_pwrite      (cfg_pwrite),
  .cfg_paddr       (cfg_paddr),
  .cfg_pwdata      (cfg_pwdata),
  .cfg_prdata      (cfg_prdata),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_best_mid    (out_best_mid),
  .out_best_top    (out_best_top),
  .out_total_coins (out_total_coins)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for greedy_coin_set_search_top: directed and random coin sets,
// with its own greedy-count search predictor. Depends on gcs_pkg and the block's RTL.
module tb;
  import gcs_pkg::*;

  localparam int          CYCLE_LIMIT = 4_000_000;
  localparam int          LONG_HOLD   = 3000;
  localparam int          TAIL_CYCLES = 64;
  localparam longint      ITEM_BUDGET = 5000;
  localparam logic [ADDR_W-1:0] MAX_AMOUNT_ADDR = {REG_MAX_AMOUNT, 2'b00};

  typedef struct packed {
    amt_t   mid;
    amt_t   top;
    total_t total;
  } coin_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_EVAL;
  amt_t        in_coin_small = '0;
  amt_t        in_coin_mid = '0;
  amt_t        in_coin_top = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  amt_t        out_best_mid;
  amt_t        out_best_top;
  total_t      out_total_coins;

  greedy_coin_set_search_top dut (.*);

  always #6 clk = ~clk;

  // predictor state
  int unsigned     amount_limit = MAX_AMOUNT_RST;
  int unsigned     greedy_tbl [0:(1 << AMOUNT_W) - 1];
  longint unsigned best_total_q;
  int unsigned     best_mid_q, best_top_q;

  coin_result_t pending_results [$];
  int           mismatches = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  bit           steady_input = 1'b0;
  int           hold_requests = 0;
  int           hold_served = 0;
  int           hold_left = 0;
  logic [15:0]  ready_pat = '1;
  int           pat_left = 0;

  function automatic int unsigned sat_add(int unsigned v, int unsigned k);
    return (v + k > AMOUNT_MAX) ? AMOUNT_MAX : v + k;
  endfunction

  // count for every amount 0..d paid with mid, small and ones
  function automatic void build_table(int unsigned coin_s, int unsigned mid, int unsigned d);
    int unsigned r, c;
    for (int unsigned a = 0; a <= d; a++) begin
      r = a;
      c = 0;
      if (mid != 0) begin
        c += r / mid;
        r %= mid;
      end
      if (coin_s != 0) begin
        c += r / coin_s;
        r %= coin_s;
      end
      greedy_tbl[a] = c + r;
    end
  endfunction

  function automatic longint unsigned sum_amounts(int unsigned top, int unsigned d);
    longint unsigned total;
    int unsigned     q, r;
    total = 0;
    q = 0;
    r = 0;
    for (int unsigned a = 1; a <= d; a++) begin
      if (top == 0) begin
        r = a;
      end else begin
        r++;
        if (r == top) begin
          r = 0;
          q++;
        end
      end
      total += q + greedy_tbl[r];
    end
    return total;
  endfunction

  function automatic void try_coin_set(int unsigned mid, int unsigned top, int unsigned d,
                                       bit first);
    longint unsigned t;
    t = sum_amounts(top, d);
    if (first || t < best_total_q) begin
      best_total_q = t;
      best_mid_q   = mid;
      best_top_q   = top;
    end
  endfunction

  function automatic coin_result_t predict_search(cmd_t c, amt_t s_, amt_t m_, amt_t t_);
    int unsigned  d, lo;
    coin_result_t r;
    d = amount_limit;
    case (c)
      CMD_EVAL: begin
        build_table(s_, m_, d);
        try_coin_set(m_, t_, d, 1'b1);
      end
      CMD_TOP: begin
        build_table(s_, m_, d);
        lo = sat_add(m_, 1);
        try_coin_set(m_, lo, d, 1'b1);
        for (int unsigned j = lo + 1; j <= d; j++) try_coin_set(m_, j, d, 1'b0);
      end
      CMD_MID: begin
        lo = sat_add(s_, 1);
        build_table(s_, lo, d);
        try_coin_set(lo, t_, d, 1'b1);
        for (int unsigned i = lo + 1; i < t_; i++) begin
          build_table(s_, i, d);
          try_coin_set(i, t_, d, 1'b0);
        end
      end
      default: begin
        lo = sat_add(s_, 1);
        build_table(s_, lo, d);
        try_coin_set(lo, sat_add(s_, 2), d, 1'b1);
        for (int unsigned i = lo; i < d; i++) begin
          build_table(s_, i, d);
          for (int unsigned j = i + 1; j <= d; j++) try_coin_set(i, j, d, 1'b0);
        end
      end
    endcase
    r.mid   = amt_t'(best_mid_q);
    r.top   = amt_t'(best_top_q);
    r.total = total_t'(best_total_q);
    return r;
  endfunction

  // rough block cycles for one item, used to keep random items cheap
  function automatic longint unsigned est_cycles(cmd_t c, amt_t s_, amt_t m_, amt_t t_,
                                                 int unsigned d);
    longint unsigned sets, fills, lo, span;
    sets  = 1;
    fills = 1;
    case (c)
      CMD_EVAL: ;
      CMD_TOP: begin
        lo = sat_add(m_, 1);
        sets = 1 + ((d > lo) ? d - lo : 0);
      end
      CMD_MID: begin
        lo = sat_add(s_, 1);
        sets = 1 + ((t_ > lo + 1) ? t_ - lo - 1 : 0);
        fills = sets;
      end
      default: begin
        lo = sat_add(s_, 1);
        span = (d > lo) ? d - lo + 1 : 0;
        sets = 1 + span * (span + 1) / 2;
        fills = 1 + span;
      end
    endcase
    return sets * (d + 3) + fills * (d + 2) + 8;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("tb: mismatch: %s", msg);
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v)
      note_mismatch($sformatf("%s expected %0d actual %0d", name, exp_v, act_v));
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    coin_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected item mid %0d top %0d total %0d",
                                out_best_mid, out_best_top, out_total_coins));
      end else begin
        exp_r = pending_results.pop_front();
        check_field("best_mid", exp_r.mid, out_best_mid);
        check_field("best_top", exp_r.top, out_best_top);
        check_field("total_coins", exp_r.total, out_total_coins);
      end
    end
  end

  // receiver stalls: long hold on request, otherwise a changing ready pattern
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= LONG_HOLD;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_left <= $urandom_range(20, 80);
        case ($urandom_range(0, 3))
          0: ready_pat <= '1;
          1: ready_pat <= 16'($urandom);
          2: ready_pat <= 16'($urandom | $urandom);
          default: ready_pat <= 16'($urandom & $urandom);
        endcase
      end else begin
        pat_left <= pat_left - 1;
      end
      out_ready <= ready_pat[pat_left[3:0]];
    end
  end

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= MAX_AMOUNT_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic read_max_amount(input int unsigned exp_v);
    logic [31:0] rd;
    apb_xfer(1'b0, '0, rd);
    check_field("max_amount readback", exp_v, rd[AMOUNT_W-1:0]);
  endtask

  task automatic set_max_amount(input int unsigned v);
    logic [31:0] rd;
    apb_xfer(1'b1, 32'(v), rd);
    amount_limit = v & AMOUNT_MAX;
    read_max_amount(amount_limit);
  endtask

  task automatic wait_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_set(input cmd_t c, input amt_t s_, input amt_t m_, input amt_t t_);
    int unsigned gap;
    gap = 0;
    if (!steady_input) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
      end
      burst_left--;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= c;
    in_coin_small <= s_;
    in_coin_mid   <= m_;
    in_coin_top   <= t_;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_search(c, s_, m_, t_));
  endtask

  task automatic test_reset_value;
    read_max_amount(MAX_AMOUNT_RST);
  endtask

  task automatic test_directed_default;
    send_set(CMD_EVAL, 10'd5, 10'd10, 10'd50);
    send_set(CMD_EVAL, 10'd0, 10'd0, 10'd0);
    send_set(CMD_EVAL, 10'd1023, 10'd1023, 10'd1023);
    send_set(CMD_EVAL, 10'd50, 10'd10, 10'd5);
    send_set(CMD_TOP, 10'd5, 10'd10, 10'd1023);
    send_set(CMD_TOP, 10'd5, 10'd1023, 10'd7);
    send_set(CMD_MID, 10'd5, 10'd1023, 10'd30);
    send_set(CMD_MID, 10'd1023, 10'd3, 10'd40);
    send_set(CMD_MID, 10'd0, 10'd0, 10'd3);
    send_set(CMD_PAIR, 10'd97, 10'd0, 10'd0);
    send_set(CMD_PAIR, 10'd1022, 10'd1, 10'd2);
    wait_results;
  endtask

  task automatic test_zero_amount;
    set_max_amount(0);
    send_set(CMD_EVAL, 10'd5, 10'd10, 10'd50);
    send_set(CMD_TOP, 10'd1, 10'd2, 10'd3);
    send_set(CMD_MID, 10'd2, 10'd0, 10'd9);
    send_set(CMD_PAIR, 10'd0, 10'd0, 10'd0);
    wait_results;
  endtask

  task automatic test_min_amount;
    set_max_amount(1);
    send_set(CMD_EVAL, 10'd1, 10'd1, 10'd1);
    send_set(CMD_PAIR, 10'd0, 10'd7, 10'd9);
    wait_results;
  endtask

  task automatic test_max_amount;
    set_max_amount(AMOUNT_MAX);
    send_set(CMD_EVAL, 10'd1, 10'd1, 10'd1);
    send_set(CMD_EVAL, 10'h2AA, 10'h155, 10'h3FF);
    send_set(CMD_TOP, 10'd5, 10'd1020, 10'd0);
    send_set(CMD_MID, 10'd1015, 10'd0, 10'd1023);
    send_set(CMD_PAIR, 10'd1020, 10'd0, 10'd0);
    wait_results;
  endtask

  task automatic test_full_pair_search;
    set_max_amount(20);
    send_set(CMD_PAIR, 10'd1, 10'd0, 10'd0);
    send_set(CMD_PAIR, 10'd4, 10'h3FF, 10'h3FF);
    wait_results;
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure;
    set_max_amount(6);
    steady_input = 1'b1;
    hold_requests++;
    repeat (12)
      send_set(cmd_t'($urandom_range(0, 3)), amt_t'($urandom_range(0, 15)),
               amt_t'($urandom_range(0, 15)), amt_t'($urandom_range(0, 15)));
    steady_input = 1'b0;
    wait_results;
  endtask

  task automatic random_phase(input int unsigned d, input int n);
    cmd_t        c;
    amt_t        s_, m_, t_;
    int unsigned hi;
    int          tries;
    wait_results;
    set_max_amount(d);
    steady_input = ($urandom_range(0, 3) == 0);
    hi = (d == 0) ? 1 : d;
    for (int k = 0; k < n; k++) begin
      tries = 0;
      do begin
        c = cmd_t'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0) begin
          s_ = amt_t'($urandom);
          m_ = amt_t'($urandom);
          t_ = amt_t'($urandom);
        end else begin
          s_ = amt_t'(sat_add($urandom_range(1, hi), 0));
          m_ = amt_t'(sat_add(s_, $urandom_range(1, hi)));
          t_ = amt_t'(sat_add(m_, $urandom_range(1, hi)));
        end
        tries++;
      end while (est_cycles(c, s_, m_, t_, d) > ITEM_BUDGET && tries < 40);
      if (est_cycles(c, s_, m_, t_, d) > ITEM_BUDGET) c = CMD_EVAL;
      if (k == n / 2) wait_results;
      send_set(c, s_, m_, t_);
    end
  endtask

  task automatic test_random;
    random_phase($urandom_range(2, 16), 20);
    random_phase($urandom_range(17, 48), 20);
    random_phase($urandom_range(49, 200), 20);
    random_phase(AMOUNT_MAX, 6);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_value;
    test_directed_default;
    test_zero_amount;
    test_min_amount;
    test_max_amount;
    test_full_pair_search;
    test_backpressure;
    test_random;
    wait_results;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
